// ----- hw/rtl/nand_page_program_rule_tracker_top_defines.svh -----
// Assertion helpers for the page program rule tracker.
`ifndef NAND_PAGE_PROGRAM_RULE_TRACKER_TOP_DEFINES_SVH
`define NAND_PAGE_PROGRAM_RULE_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define NPPR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nppr check failed");

// Next-cycle implication, off during reset.
`define NPPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nppr check failed");

`endif

// ----- hw/rtl/nppr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nppr_pkg;

  localparam int NUM_BLOCKS    = 1024;
  localparam int PAGES_PER_BLK = 64;

  localparam int BLK_AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int PG_AW  = (PAGES_PER_BLK > 1) ? $clog2(PAGES_PER_BLK) : 1;

  localparam int KIND_W   = 2;
  localparam int BLOCK_W  = 12;
  localparam int PAGE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;
  localparam int CURSOR_W = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int LIMIT_W    = 4;
  localparam int BIU_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;
  localparam logic [BIU_W-1:0]   BIU_RESET   = 11'd1024;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHECK = 2'd0,
    KIND_NOTE  = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BLOCK_RANGE = 2'd1,
    ST_PAGE_RANGE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               mark;
  } page_entry_t;

  typedef struct packed {
    logic [CURSOR_W-1:0]                       cursor;
    page_entry_t [PAGES_PER_BLK-1:0]           pages;
  } block_row_t;

  typedef struct packed {
    logic              capture;
    logic              exec;
    logic              clr_wr;
    logic [BLK_AW-1:0] clr_addr;
  } nppr_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/nppr_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface nppr_req_if;
  logic                          valid;
  logic                          ready;
  logic [nppr_pkg::KIND_W-1:0]   kind;
  logic [nppr_pkg::BLOCK_W-1:0]  blk_addr;
  logic [nppr_pkg::PAGE_W-1:0]   page_index;

  modport source (output valid, kind, blk_addr, page_index, input ready);
  modport sink   (input valid, kind, blk_addr, page_index, output ready);
endinterface

interface nppr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           allowed;
  logic [nppr_pkg::STATUS_W-1:0]  status;
  logic [nppr_pkg::COUNT_W-1:0]   count_after;
  logic [nppr_pkg::CURSOR_W-1:0]  cursor_after;
  logic                           page_written;

  modport source (output valid, allowed, status, count_after, cursor_after, page_written,
                  input ready);
  modport sink   (input valid, allowed, status, count_after, cursor_after, page_written,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/nppr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nppr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output nppr_pkg::nppr_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                      state;
  logic [nppr_pkg::BLK_AW-1:0] clr_addr;
  logic                        out_valid;

  localparam logic [nppr_pkg::BLK_AW-1:0] LAST_ROW =
    nppr_pkg::BLK_AW'(nppr_pkg::NUM_BLOCKS - 1);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && req_valid;
    cmd.exec     = (state == S_EXEC) && (!out_valid || rsp_ready);
    cmd.clr_wr   = (state == S_CLEAR);
    cmd.clr_addr = clr_addr;
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ROW) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.exec) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/nppr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nppr_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire nppr_pkg::nppr_cmd_t                 cmd,
  input  wire logic                                cfg_wr_en,
  input  wire logic [nppr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nppr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [nppr_pkg::KIND_W-1:0]         in_kind,
  input  wire logic [nppr_pkg::BLOCK_W-1:0]        in_block,
  input  wire logic [nppr_pkg::PAGE_W-1:0]         in_page,
  output logic                                     allowed,
  output logic [nppr_pkg::STATUS_W-1:0]            status,
  output logic [nppr_pkg::COUNT_W-1:0]             count_after,
  output logic [nppr_pkg::CURSOR_W-1:0]            cursor_after,
  output logic                                     page_written
);

  localparam logic [nppr_pkg::BLOCK_W:0] NUM_BLOCKS_C =
    (nppr_pkg::BLOCK_W + 1)'(nppr_pkg::NUM_BLOCKS);
  localparam logic [nppr_pkg::CURSOR_W-1:0] PAGES_C =
    nppr_pkg::CURSOR_W'(nppr_pkg::PAGES_PER_BLK);

  nppr_pkg::block_row_t mem [nppr_pkg::NUM_BLOCKS];

  logic [nppr_pkg::LIMIT_W-1:0] limit;
  logic                         strict;
  logic [nppr_pkg::BIU_W-1:0]   blocks_in_use;

  nppr_pkg::kind_t              kind_q;
  logic [nppr_pkg::BLOCK_W-1:0] blk_q;
  logic [nppr_pkg::PAGE_W-1:0]  pg_q;
  nppr_pkg::block_row_t         rd_row;

  logic                          blk_ok;
  logic                          pg_ok;
  logic [nppr_pkg::PG_AW-1:0]    pg_idx;
  logic [nppr_pkg::CURSOR_W-1:0] pg_ext;
  nppr_pkg::page_entry_t         entry;
  nppr_pkg::page_entry_t         entry_new;
  logic [nppr_pkg::CURSOR_W-1:0] cur_new;
  nppr_pkg::block_row_t          row_wr;
  logic                          row_we;

  logic                              allowed_next;
  nppr_pkg::status_t                 status_next;
  logic [nppr_pkg::COUNT_W-1:0]      count_next;
  logic [nppr_pkg::CURSOR_W-1:0]     cursor_next;
  logic                              written_next;

  logic                         mem_we;
  logic [nppr_pkg::BLK_AW-1:0]  mem_waddr;
  nppr_pkg::block_row_t         mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit         <= nppr_pkg::LIMIT_RESET;
      strict        <= 1'b1;
      blocks_in_use <= nppr_pkg::BIU_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        nppr_pkg::CFG_LIMIT:  limit         <= cfg_data[nppr_pkg::LIMIT_W-1:0];
        nppr_pkg::CFG_STRICT: strict        <= cfg_data[0];
        nppr_pkg::CFG_BLOCKS: blocks_in_use <= cfg_data[nppr_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= nppr_pkg::kind_t'(in_kind);
      blk_q  <= in_block;
      pg_q   <= in_page;
      rd_row <= mem[in_block[nppr_pkg::BLK_AW-1:0]];
    end
  end

  always_comb begin
    blk_ok  = ({1'b0, blk_q} < {{(nppr_pkg::BLOCK_W + 1 - nppr_pkg::BIU_W){1'b0}},
                                 blocks_in_use})
              && ({1'b0, blk_q} < NUM_BLOCKS_C);
    pg_ext  = {1'b0, pg_q};
    pg_ok   = pg_ext < PAGES_C;
    pg_idx  = pg_q[nppr_pkg::PG_AW-1:0];
    entry   = rd_row.pages[pg_idx];

    entry_new = entry;
    cur_new   = rd_row.cursor;
    row_wr    = rd_row;
    row_we    = 1'b0;

    allowed_next = 1'b0;
    status_next  = nppr_pkg::ST_OK;
    count_next   = '0;
    cursor_next  = '0;
    written_next = 1'b0;

    if (!blk_ok) begin
      status_next = nppr_pkg::ST_BLOCK_RANGE;
    end else if (kind_q == nppr_pkg::KIND_ERASE) begin
      row_wr = '0;
      row_we = 1'b1;
    end else if (!pg_ok) begin
      status_next = nppr_pkg::ST_PAGE_RANGE;
      cursor_next = rd_row.cursor;
    end else begin
      if (kind_q == nppr_pkg::KIND_NOTE) begin
        entry_new.mark = 1'b1;
        if (entry.count != nppr_pkg::COUNT_MAX) begin
          entry_new.count = entry.count + 1'b1;
        end
        if (pg_ext >= rd_row.cursor) begin
          cur_new = pg_ext + 1'b1;
        end
        row_wr.pages[pg_idx] = entry_new;
        row_wr.cursor        = cur_new;
        row_we               = 1'b1;
      end else if (kind_q == nppr_pkg::KIND_CHECK) begin
        allowed_next = (entry.count < limit) && (!strict || (pg_ext <= rd_row.cursor));
      end
      count_next   = entry_new.count;
      written_next = entry_new.mark;
      cursor_next  = cur_new;
    end
  end

  always_comb begin
    if (cmd.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cmd.clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.exec && row_we;
      mem_waddr = blk_q[nppr_pkg::BLK_AW-1:0];
      mem_wdata = row_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      allowed      <= allowed_next;
      status       <= status_next;
      count_after  <= count_next;
      cursor_after <= cursor_next;
      page_written <= written_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/nand_page_program_rule_tracker_top.sv -----
// Flow: an accepted request is captured with its block row, then its result is
//   registered in S_EXEC, which waits only while the previous result awaits rsp.ready.
// One request at a time for every kind, erase included: req.ready stays low across the
//   read and, for note and erase, write-back of one block row (all pages plus cursor).
// Reset: rst resets control and config to defaults; a clearing pass then zeroes
//   all NUM_BLOCKS (1024) rows, req.ready low. Config writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module nand_page_program_rule_tracker_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [nppr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nppr_pkg::CFG_DATA_W-1:0]  cfg_data,
  nppr_req_if.sink                              req,
  nppr_rsp_if.source                            rsp
);

  nppr_pkg::nppr_cmd_t cmd;

  nppr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  nppr_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_kind      (req.kind),
    .in_block     (req.blk_addr),
    .in_page      (req.page_index),
    .allowed      (rsp.allowed),
    .status       (rsp.status),
    .count_after  (rsp.count_after),
    .cursor_after (rsp.cursor_after),
    .page_written (rsp.page_written)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/nppr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "nand_page_program_rule_tracker_top_defines.svh"
module nppr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic                            allowed,
  input wire logic [nppr_pkg::STATUS_W-1:0]   status,
  input wire logic [nppr_pkg::COUNT_W-1:0]    count_after,
  input wire logic [nppr_pkg::CURSOR_W-1:0]   cursor_after,
  input wire logic                            page_written
);

  // one request in flight: ready drops after each accepted request
  `NPPR_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  `NPPR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  `NPPR_ASSERT_NOW(a_allowed_ok, clk, rst, rsp_valid && allowed,
                   status == nppr_pkg::ST_OK)

  `NPPR_ASSERT_NOW(a_block_range_zero, clk, rst,
                   rsp_valid && (status == nppr_pkg::ST_BLOCK_RANGE),
                   (count_after == '0) && (cursor_after == '0) && !page_written)

endmodule

bind nand_page_program_rule_tracker_top nppr_checker u_nppr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .allowed      (rsp.allowed),
  .status       (rsp.status),
  .count_after  (rsp.count_after),
  .cursor_after (rsp.cursor_after),
  .page_written (rsp.page_written)
);
`default_nettype wire
